/* hw/rtl/sha1hs_pkg.sv */
// sha1 stream hasher package: initial hash, round constants, round function
// and the control/status structs shared by the top level and the round core
// no dependencies

package sha1hs_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam logic [6:0]  LAST_ROUND = 7'(NUM_ROUNDS - 1);

    typedef struct packed {
        logic       put;
        logic [7:0] put_byte;
        logic       word_end;
        logic       start;
        logic       reload;
    } t_core_ctrl;

    typedef struct packed {
        logic done;
    } t_core_stat;

    function automatic logic [31:0] sha1hs_f(input logic [6:0] t, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            r = b ^ c ^ d;
        end else if (t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [31:0] sha1hs_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = K0;
        end else if (t < 7'd40) begin
            r = K1;
        end else if (t < 7'd60) begin
            r = K2;
        end else begin
            r = K3;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/sha1hs_core.sv */
// sha1 round core: chaining words, working variables, 16-word schedule line
// and one round unit reused for all 80 rounds of a block
// depends on sha1hs_pkg

module sha1hs_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1hs_pkg::t_core_ctrl i_ctrl,
    output sha1hs_pkg::t_core_stat o_stat,
    output logic [159:0]           o_chain
);
    import sha1hs_pkg::*;

    logic [31:0] r_chain [5];
    logic [31:0] r_var   [5];
    logic [31:0] r_w     [16];
    logic [23:0] r_acc;
    logic [6:0]  r_round;
    logic        r_busy;
    logic        r_fin;

    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [31:0] w_t;
    logic [31:0] round_sum;
    logic [31:0] shift_in;
    logic        shift_en;

    assign w_mix     = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new     = {w_mix[30:0], w_mix[31]};
    assign w_t       = (r_round < 7'd16) ? r_w[0] : w_new;
    assign round_sum = {r_var[0][26:0], r_var[0][31:27]}
                     + sha1hs_f(r_round, r_var[1], r_var[2], r_var[3])
                     + r_var[4] + sha1hs_k(r_round) + w_t;

    assign shift_en = r_busy || (i_ctrl.put && i_ctrl.word_end);
    assign shift_in = r_busy ? w_t : {r_acc, i_ctrl.put_byte};

    // byte packing and schedule line
    always_ff @(posedge i_clk) begin
        if (i_ctrl.put) begin
            r_acc <= {r_acc[15:0], i_ctrl.put_byte};
        end
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= shift_in;
        end
    end

    // round sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_ctrl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                if (r_round == LAST_ROUND) begin
                    r_busy  <= 1'b0;
                    r_fin   <= 1'b1;
                    r_round <= '0;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            for (int i = 0; i < 5; i++) begin
                r_var[i] <= r_chain[i];
            end
        end else if (r_busy) begin
            r_var[4] <= r_var[3];
            r_var[3] <= r_var[2];
            r_var[2] <= {r_var[1][1:0], r_var[1][31:2]};
            r_var[1] <= r_var[0];
            r_var[0] <= round_sum;
        end
    end

    // chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.reload) begin
            r_chain[0] <= IV0;
            r_chain[1] <= IV1;
            r_chain[2] <= IV2;
            r_chain[3] <= IV3;
            r_chain[4] <= IV4;
        end else if (r_fin) begin
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= r_chain[i] + r_var[i];
            end
        end
    end

    assign o_stat.done = r_fin;
    assign o_chain     = {r_chain[4], r_chain[3], r_chain[2], r_chain[1], r_chain[0]};

endmodule

/* hw/rtl/sha1_hash_stream.sv */
// SHA-1 over a byte stream, at most one byte per input transfer. Input is
// taken only in the idle state; the transfer that fills a 64-byte block is
// followed by a busy phase of the single round unit (80 rounds, then the
// chain update). Closing a message pads one byte per cycle, held while a
// filled block is compressed, and runs one or two further compressions
// before the digest is offered; the next message can be taken while the
// digest still waits on the output.
// depends on sha1hs_pkg and sha1hs_core

module sha1_hash_stream (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // msg_byte
    input  logic         s_axis_tuser,  // byte_present
    input  logic         s_axis_tlast,  // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata   // digest_h0 in bits 31:0 up to digest_h4 in bits 159:128
);
    import sha1hs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PADM = 6'b000010,
        ST_PADZ = 6'b000100,
        ST_PADL = 6'b001000,
        ST_COMP = 6'b010000,
        ST_OUTW = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_MARK = 2'd1,
        RET_PAD  = 2'd2,
        RET_OUT  = 2'd3
    } t_ret;

    t_state       r_state, n_state;
    t_ret         r_ret, n_ret;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_bitlen, n_bitlen;
    logic         r_m_valid;
    logic [159:0] r_m_data;
    logic         load_out;

    t_core_ctrl   ctrl;
    t_core_stat   stat;
    logic [159:0] chain;

    logic         s_xfer;
    logic         full;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_fill == 6'd63);

    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_fill        = r_fill;
        n_bitlen      = r_bitlen;
        load_out      = 1'b0;
        ctrl.put      = 1'b0;
        ctrl.put_byte = 8'd0;
        ctrl.word_end = (r_fill[1:0] == 2'b11);
        ctrl.start    = 1'b0;
        ctrl.reload   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_axis_tuser) begin
                        ctrl.put      = 1'b1;
                        ctrl.put_byte = s_axis_tdata;
                        n_fill        = r_fill + 6'd1;
                        n_bitlen      = r_bitlen + 64'd8;
                    end
                    if (s_axis_tuser && full) begin
                        ctrl.start = 1'b1;
                        n_ret      = s_axis_tlast ? RET_MARK : RET_IDLE;
                        n_state    = ST_COMP;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PADM;
                    end
                end
            end
            ST_PADM: begin
                ctrl.put      = 1'b1;
                ctrl.put_byte = PAD_MARK;
                n_fill        = r_fill + 6'd1;
                if (full) begin
                    ctrl.start = 1'b1;
                    n_ret      = RET_PAD;
                    n_state    = ST_COMP;
                end else begin
                    n_state = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (r_fill == 6'd56) begin
                    n_state = ST_PADL;
                end else begin
                    ctrl.put = 1'b1;
                    n_fill   = r_fill + 6'd1;
                    if (full) begin
                        ctrl.start = 1'b1;
                        n_ret      = RET_PAD;
                        n_state    = ST_COMP;
                    end
                end
            end
            ST_PADL: begin
                ctrl.put      = 1'b1;
                ctrl.put_byte = r_bitlen[63:56];
                n_bitlen      = {r_bitlen[55:0], 8'd0};
                n_fill        = r_fill + 6'd1;
                if (full) begin
                    ctrl.start = 1'b1;
                    n_ret      = RET_OUT;
                    n_state    = ST_COMP;
                end
            end
            ST_COMP: begin
                if (stat.done) begin
                    unique case (r_ret)
                        RET_IDLE: n_state = ST_IDLE;
                        RET_MARK: n_state = ST_PADM;
                        RET_PAD:  n_state = ST_PADZ;
                        RET_OUT:  n_state = ST_OUTW;
                    endcase
                end
            end
            ST_OUTW: begin
                if (!r_m_valid || m_axis_tready) begin
                    load_out    = 1'b1;
                    ctrl.reload = 1'b1;
                    n_bitlen    = 64'd0;
                    n_fill      = 6'd0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret     <= RET_IDLE;
            r_fill    <= 6'd0;
            r_bitlen  <= 64'd0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_data <= chain;
        end
    end

    sha1hs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_chain (chain)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

/* hw/rtl/sha1hs_checker.sv */
// port-level checks for the sha1 stream hasher, bound to the top level
// depends on sha1_hash_stream ports only

module sha1hs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);

    // a stalled digest stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("digest dropped while stalled");

    // a stalled digest keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // closing transfer starts padding or a compression, input goes busy
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after closing transfer");

    // a new digest appears only as the block leaves its busy phase
    a_digest_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
        else $error("digest appeared outside end of message");

endmodule

bind sha1_hash_stream sha1hs_checker u_sha1hs_checker (.*);

/* sim/tb_sha1_hash_stream.sv */
// testbench for sha1_hash_stream: streams messages byte by byte, predicts each digest with
// its own sha-1 model and checks every digest transfer field by field
// depends on sha1hs_pkg and the sha1_hash_stream rtl
`timescale 1ns / 100ps

module tb_sha1_hash_stream;

    import sha1hs_pkg::IV0;
    import sha1hs_pkg::IV1;
    import sha1hs_pkg::IV2;
    import sha1hs_pkg::IV3;
    import sha1hs_pkg::IV4;
    import sha1hs_pkg::K0;
    import sha1hs_pkg::K1;
    import sha1hs_pkg::K2;
    import sha1hs_pkg::K3;
    import sha1hs_pkg::PAD_MARK;

    localparam int RANDOM_ITEMS = 1750;
    localparam int MIN_DIGESTS  = 40;
    localparam int PARK_CYCLES  = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 400;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;  // msg_byte
    logic         s_axis_tuser = 1'b0;   // byte_present
    logic         s_axis_tlast = 1'b0;   // last
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;          // digest_h0 in bits 31:0 up to digest_h4 in bits 159:128

    logic [31:0]  hash_chain [5];
    logic [7:0]   block_buf [64];
    int unsigned  block_fill_cnt;
    logic [63:0]  msg_bit_len;
    logic [159:0] expected_digests [$];

    int  n_errors = 0;
    int  n_items = 0;
    int  n_digests_predicted = 0;
    int  idle_cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  park_req = 1'b0;

    sha1_hash_stream i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void load_initial_hash();
        hash_chain[0] = IV0;
        hash_chain[1] = IV1;
        hash_chain[2] = IV2;
        hash_chain[3] = IV3;
        hash_chain[4] = IV4;
        msg_bit_len = 64'd0;
        block_fill_cnt = 0;
    endfunction

    function automatic void sha1_compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, sum, x;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                x = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
                w[t % 16] = {x[30:0], x[31]};
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + w[t % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    function automatic void sha1_absorb_byte(input logic [7:0] b);
        block_buf[block_fill_cnt] = b;
        block_fill_cnt++;
        if (block_fill_cnt == 64) begin
            sha1_compress_block();
            block_fill_cnt = 0;
        end
    endfunction

    // advance the hash state by one accepted transfer, queue the digest on close
    function automatic void sha1_take_item(input logic [7:0] b, input logic present,
                                           input logic close);
        logic [159:0] digest;
        if (present) begin
            sha1_absorb_byte(b);
            msg_bit_len += 64'd8;
        end
        if (close) begin
            sha1_absorb_byte(PAD_MARK);
            while (block_fill_cnt != 56) sha1_absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) block_buf[56 + i] = msg_bit_len[8*(7-i) +: 8];
            sha1_compress_block();
            digest = {hash_chain[4], hash_chain[3], hash_chain[2], hash_chain[1], hash_chain[0]};
            expected_digests.insert(expected_digests.size(), digest);
            n_digests_predicted++;
            load_initial_hash();
        end
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic present, input logic close);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= close;
        do @(posedge i_clk); while (!s_axis_tready);
        sha1_take_item(b, present, close);
        if (present || close) n_items++;
    endtask

    // len bytes; absent bytes sprinkled in at noise_pct percent
    task automatic send_message(input int len, input int noise_pct, input bit close_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_digests_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_digests.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        wait_digests_drained();
    endtask

    task automatic test_output_stall();
        tx_idle_on = 1'b0;
        park_req = 1'b1;
        for (int m = 0; m < 4; m++) begin
            send_message(int'($urandom_range(1, 20)), 0, 1'($urandom_range(0, 1)));
        end
        wait_digests_drained();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_message(64, 10, 1'b1);
        wait_digests_drained();
        send_message(3, 0, 1'b0);
        wait_digests_drained();
    endtask

    task automatic test_random_messages();
        int edge_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int pick, len;
        while (n_items < RANDOM_ITEMS || n_digests_predicted < MIN_DIGESTS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 3) len = edge_lens[$urandom_range(0, 9)];
            else if (pick == 3) len = $urandom_range(100, 200);
            else len = $urandom_range(0, 40);
            send_message(len, ($urandom_range(0, 4) == 0) ? 20 : 0, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) wait_digests_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : digest_sink
        int wait_left;
        logic [159:0] want;
        wait_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_digests.size() == 0) begin
                    report_error($sformatf("digest transfer with none expected: %040h",
                                           m_axis_tdata));
                end else begin
                    want = expected_digests.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                            report_error($sformatf("digest_h%0d expected %08h got %08h", i,
                                                   want[32*i +: 32], m_axis_tdata[32*i +: 32]));
                        end
                    end
                end
                wait_left = rx_idle_on ? $urandom_range(0, 6) : 0;
            end
            @(negedge i_clk);
            if (park_req) begin
                park_req = 1'b0;
                wait_left = PARK_CYCLES;
            end
            if (wait_left > 0) begin
                m_axis_tready <= 1'b0;
                wait_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        load_initial_hash();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_output_stall();
        test_sender_pause();
        test_random_messages();
        wait_digests_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
